// ----- sv/mbb_pkg.sv -----
// Shared types, constants and box arithmetic for the mask blob bounding-box block.
// No dependencies; every other file but mbb_ram imports this package.
package mbb_pkg;

	localparam int MAX_BOXES  = 64;
	localparam int COORD_BITS = 12;
	localparam int SIZE_W     = COORD_BITS + 1;
	localparam int SUM_W      = COORD_BITS + 2;
	localparam int IDX_W      = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CNT_W      = $clog2(MAX_BOXES + 1);
	localparam int BOX_W      = 2 * COORD_BITS + 2 * SIZE_W;
	localparam int ADDR_W     = 4;
	localparam logic [SIZE_W-1:0] FRAME_MAX = SIZE_W'(1 << COORD_BITS);

	localparam logic [ADDR_W-3:0] REG_MIN_CONF = 2'd0;
	localparam logic [ADDR_W-3:0] REG_WINDOW   = 2'd1;
	localparam logic [ADDR_W-3:0] REG_FRAME_W  = 2'd2;

	typedef struct packed {
		logic [COORD_BITS-1:0] left;
		logic [COORD_BITS-1:0] top;
		logic [SIZE_W-1:0]     width;
		logic [SIZE_W-1:0]     height;
	} box_t;

	typedef struct packed {
		logic [7:0]        min_confidence;
		logic [5:0]        window_size;
		logic [SIZE_W-1:0] frame_width;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_SWAP0, ST_SWAP1, ST_APPEND,
		ST_M_OUTER, ST_M_IRD, ST_M_ILAT, ST_M_JRD, ST_M_JCMP, ST_M_SRD, ST_M_SWR,
		ST_E_RD, ST_E_WAIT, ST_FINISH
	} state_t;

	function automatic logic [SUM_W-1:0] ext(input logic [SIZE_W-1:0] v);
		return SUM_W'(v);
	endfunction

	// Window of side s centered on (px,py), tested against box b.
	function automatic logic win_hit(input logic [COORD_BITS-1:0] px,
			input logic [COORD_BITS-1:0] py, input logic [5:0] ws, input box_t b);
		logic [5:0] side;
		logic [5:0] reach;
		logic       hx, hy;
		side  = (ws == 6'd0) ? 6'd1 : ws;
		reach = side >> 1;
		hx = (SUM_W'(px) < SUM_W'(b.left) + ext(b.width) + SUM_W'(reach)) &&
			(SUM_W'(b.left) + SUM_W'(reach) < SUM_W'(px) + SUM_W'(side));
		hy = (SUM_W'(py) < SUM_W'(b.top) + ext(b.height) + SUM_W'(reach)) &&
			(SUM_W'(b.top) + SUM_W'(reach) < SUM_W'(py) + SUM_W'(side));
		return hx && hy;
	endfunction

	function automatic logic box_hit(input box_t a, input box_t b);
		return (SUM_W'(a.left) < SUM_W'(b.left) + ext(b.width)) &&
			(SUM_W'(b.left) < SUM_W'(a.left) + ext(a.width)) &&
			(SUM_W'(a.top) < SUM_W'(b.top) + ext(b.height)) &&
			(SUM_W'(b.top) < SUM_W'(a.top) + ext(a.height));
	endfunction

	function automatic box_t grow(input box_t b, input logic [COORD_BITS-1:0] px,
			input logic [COORD_BITS-1:0] py);
		box_t           g;
		logic [SUM_W-1:0] r, d;
		g.left = (px < b.left) ? px : b.left;
		g.top  = (py < b.top) ? py : b.top;
		r = SUM_W'(b.left) + ext(b.width) - SUM_W'(1);
		if (SUM_W'(px) > r) r = SUM_W'(px);
		g.width = SIZE_W'(r - SUM_W'(g.left) + SUM_W'(1));
		d = SUM_W'(b.top) + ext(b.height) - SUM_W'(1);
		if (SUM_W'(py) > d) d = SUM_W'(py);
		g.height = SIZE_W'(d - SUM_W'(g.top) + SUM_W'(1));
		return g;
	endfunction

	function automatic box_t unite(input box_t a, input box_t b);
		box_t           u;
		logic [SUM_W-1:0] ra, rb, da, db;
		u.left = (a.left < b.left) ? a.left : b.left;
		u.top  = (a.top < b.top) ? a.top : b.top;
		ra = SUM_W'(a.left) + ext(a.width);
		rb = SUM_W'(b.left) + ext(b.width);
		da = SUM_W'(a.top) + ext(a.height);
		db = SUM_W'(b.top) + ext(b.height);
		u.width  = SIZE_W'(((ra > rb) ? ra : rb) - SUM_W'(u.left));
		u.height = SIZE_W'(((da > db) ? da : db) - SUM_W'(u.top));
		return u;
	endfunction

endpackage

// ----- sv/mbb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mbb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- sv/mbb_regs.sv -----
// APB configuration registers of the bounding-box block.
// Depends on mbb_pkg.
module mbb_regs import mbb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);
	cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_confidence <= 8'd128;
			cfg_q.window_size    <= 6'd17;
			cfg_q.frame_width    <= SIZE_W'(256);
		end else if (wr) begin
			case (paddr[ADDR_W-1:2])
				REG_MIN_CONF: cfg_q.min_confidence <= pwdata[7:0];
				REG_WINDOW:   cfg_q.window_size    <= pwdata[5:0];
				REG_FRAME_W:  cfg_q.frame_width    <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[ADDR_W-1:2])
			REG_MIN_CONF: prdata = {24'd0, cfg_q.min_confidence};
			REG_WINDOW:   prdata = {26'd0, cfg_q.window_size};
			REG_FRAME_W:  prdata = 32'(cfg_q.frame_width);
			default:      prdata = 32'd0;
		endcase
	end
endmodule

// ----- sv/mask_blob_bounding_boxes_core.sv -----
// Top level of the mask blob bounding-box block: sequencer, box table and output register.
// Depends on mbb_pkg, mbb_ram and mbb_regs.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  pixel   | in_valid, in_stall, pixel_confidence,     | request in
//          | last_pixel                                |
//  box     | out_valid, out_stall, box_present, box_x, | request out
//          | box_y, box_width, box_height, overflow,   |
//          | last_box                                  |
//  config  | psel, penable, pwrite, paddr, pwdata,     | APB slave
//          | prdata, pready                            |
//
// A background pixel other than the last of a frame leaves the sequencer idle. A
// foreground pixel scans the box table through the single read port of the table
// RAM, a read and a compare state per stored box up to the first hit, then swaps
// the grown box to the front in ST_SWAP0 and ST_SWAP1 or appends a new box.
// At the end of a frame the merge passes read and shift the table through the same port;
// each box then goes to the output register, waiting while out_stall holds it.
// Reset clears the sequencer, counters and flags; the table needs no clearing.
// in_stall is high whenever the sequencer is busy; a finished result waits in the
// output register while the next frame's pixels are taken.
module mask_blob_bounding_boxes_core import mbb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            pixel_confidence,
	input  logic                  last_pixel,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  box_present,
	output logic [COORD_BITS-1:0] box_x,
	output logic [COORD_BITS-1:0] box_y,
	output logic [SIZE_W-1:0]     box_width,
	output logic [SIZE_W-1:0]     box_height,
	output logic                  overflow,
	output logic                  last_box
);
	cfg_t cfg;

	mbb_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	// Table RAM ports.
	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	box_t             ram_wdata, ram_rdata;
	logic [BOX_W-1:0] ram_rbits;

	mbb_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_table (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.re(ram_re), .raddr(ram_raddr), .rdata(ram_rbits)
	);
	assign ram_rdata = box_t'(ram_rbits);

	state_t state_q, state_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [CNT_W-1:0]      k_q, k_d, j_q, j_d, m_q, m_d;
	logic                  merged_q, merged_d;
	logic                  ovf_q, ovf_d;
	logic                  last_q, last_d;
	logic [COORD_BITS-1:0] col_q, col_d, row_q, row_d;
	logic [COORD_BITS-1:0] px_q, px_d, py_q, py_d;
	box_t                  e0_q, e0_d, hold_q, hold_d;

	// Output register.
	logic                  ov_q, ov_d;
	logic                  o_present_q, o_present_d, o_last_q, o_last_d, o_ovf_q, o_ovf_d;
	box_t                  o_box_q, o_box_d;
	logic                  slot_free;

	logic                  accept;
	logic [SIZE_W-1:0]     fw;

	assign in_stall    = (state_q != ST_IDLE);
	assign accept      = in_valid && !in_stall;
	assign slot_free   = !ov_q || !out_stall;
	assign fw          = (cfg.frame_width > FRAME_MAX) ? FRAME_MAX : cfg.frame_width;

	assign out_valid   = ov_q;
	assign box_present = o_present_q;
	assign box_x       = o_box_q.left;
	assign box_y       = o_box_q.top;
	assign box_width   = o_box_q.width;
	assign box_height  = o_box_q.height;
	assign overflow    = o_ovf_q;
	assign last_box    = o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			k_q      <= '0;
			j_q      <= '0;
			m_q      <= '0;
			merged_q <= 1'b0;
			ovf_q    <= 1'b0;
			last_q   <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
			ov_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			k_q      <= k_d;
			j_q      <= j_d;
			m_q      <= m_d;
			merged_q <= merged_d;
			ovf_q    <= ovf_d;
			last_q   <= last_d;
			col_q    <= col_d;
			row_q    <= row_d;
			ov_q     <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		px_q        <= px_d;
		py_q        <= py_d;
		e0_q        <= e0_d;
		hold_q      <= hold_d;
		o_present_q <= o_present_d;
		o_last_q    <= o_last_d;
		o_ovf_q     <= o_ovf_d;
		o_box_q     <= o_box_d;
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		k_d         = k_q;
		j_d         = j_q;
		m_d         = m_q;
		merged_d    = merged_q;
		ovf_d       = ovf_q;
		last_d      = last_q;
		col_d       = col_q;
		row_d       = row_q;
		px_d        = px_q;
		py_d        = py_q;
		e0_d        = e0_q;
		hold_d      = hold_q;
		ov_d        = ov_q && out_stall;
		o_present_d = o_present_q;
		o_last_d    = o_last_q;
		o_ovf_d     = o_ovf_q;
		o_box_d     = o_box_q;
		ram_we      = 1'b0;
		ram_waddr   = '0;
		ram_wdata   = hold_q;
		ram_re      = 1'b0;
		ram_raddr   = '0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					px_d   = col_q;
					py_d   = row_q;
					last_d = last_pixel;
					k_d    = '0;
					if (SIZE_W'(col_q) + SIZE_W'(1) >= fw) begin
						col_d = '0;
						row_d = row_q + COORD_BITS'(1);
					end else begin
						col_d = col_q + COORD_BITS'(1);
					end
					if (pixel_confidence >= cfg.min_confidence) begin
						state_d = (count_q == '0) ? ST_APPEND : ST_SCAN_RD;
					end else if (last_pixel) begin
						state_d = ST_M_OUTER;
					end
				end
			end
			ST_SCAN_RD: begin
				ram_re    = 1'b1;
				ram_raddr = k_q[IDX_W-1:0];
				state_d   = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				if (k_q == '0) begin
					e0_d = ram_rdata;
				end
				if (win_hit(px_q, py_q, cfg.window_size, ram_rdata)) begin
					hold_d  = grow(ram_rdata, px_q, py_q);
					state_d = ST_SWAP0;
				end else begin
					k_d     = k_q + CNT_W'(1);
					state_d = (k_q + CNT_W'(1) == count_q) ? ST_APPEND : ST_SCAN_RD;
				end
			end
			ST_SWAP0: begin
				// The front entry moves into the slot of the hit box.
				ram_we    = 1'b1;
				ram_waddr = k_q[IDX_W-1:0];
				ram_wdata = e0_q;
				state_d   = ST_SWAP1;
			end
			ST_SWAP1: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = hold_q;
				state_d   = last_q ? ST_M_OUTER : ST_IDLE;
			end
			ST_APPEND: begin
				if (count_q < CNT_W'(MAX_BOXES)) begin
					ram_we    = 1'b1;
					ram_waddr = count_q[IDX_W-1:0];
					ram_wdata = '{left: px_q, top: py_q, width: SIZE_W'(1),
						height: SIZE_W'(1)};
					count_d   = count_q + CNT_W'(1);
				end else begin
					ovf_d = 1'b1;
				end
				state_d = last_q ? ST_M_OUTER : ST_IDLE;
			end
			ST_M_OUTER: begin
				k_d      = '0;
				merged_d = 1'b0;
				state_d  = ST_M_IRD;
			end
			ST_M_IRD: begin
				if (k_q >= count_q) begin
					k_d     = '0;
					state_d = merged_q ? ST_M_OUTER : ST_E_RD;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = k_q[IDX_W-1:0];
					j_d       = k_q + CNT_W'(1);
					state_d   = ST_M_ILAT;
				end
			end
			ST_M_ILAT: begin
				hold_d  = ram_rdata;
				state_d = ST_M_JRD;
			end
			ST_M_JRD: begin
				if (j_q >= count_q) begin
					// Box i is final for this pass; store it back.
					ram_we    = 1'b1;
					ram_waddr = k_q[IDX_W-1:0];
					ram_wdata = hold_q;
					k_d       = k_q + CNT_W'(1);
					state_d   = ST_M_IRD;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = j_q[IDX_W-1:0];
					state_d   = ST_M_JCMP;
				end
			end
			ST_M_JCMP: begin
				if (box_hit(hold_q, ram_rdata)) begin
					hold_d   = unite(hold_q, ram_rdata);
					merged_d = 1'b1;
					m_d      = j_q;
					state_d  = ST_M_SRD;
				end else begin
					j_d     = j_q + CNT_W'(1);
					state_d = ST_M_JRD;
				end
			end
			ST_M_SRD: begin
				if (m_q + CNT_W'(1) >= count_q) begin
					count_d = count_q - CNT_W'(1);
					state_d = ST_M_JRD;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = IDX_W'(m_q + CNT_W'(1));
					state_d   = ST_M_SWR;
				end
			end
			ST_M_SWR: begin
				ram_we    = 1'b1;
				ram_waddr = m_q[IDX_W-1:0];
				ram_wdata = ram_rdata;
				m_d       = m_q + CNT_W'(1);
				state_d   = ST_M_SRD;
			end
			ST_E_RD: begin
				if (count_q == '0) begin
					// Empty frame: one result without a box.
					if (slot_free) begin
						ov_d        = 1'b1;
						o_present_d = 1'b0;
						o_box_d     = '0;
						o_ovf_d     = ovf_q;
						o_last_d    = 1'b1;
						state_d     = ST_FINISH;
					end
				end else begin
					ram_re    = 1'b1;
					ram_raddr = k_q[IDX_W-1:0];
					state_d   = ST_E_WAIT;
				end
			end
			ST_E_WAIT: begin
				if (slot_free) begin
					ov_d        = 1'b1;
					o_present_d = 1'b1;
					o_box_d     = ram_rdata;
					o_ovf_d     = ovf_q;
					o_last_d    = (k_q + CNT_W'(1) == count_q);
					k_d         = k_q + CNT_W'(1);
					state_d     = (k_q + CNT_W'(1) == count_q) ? ST_FINISH : ST_E_RD;
				end
			end
			ST_FINISH: begin
				count_d = '0;
				col_d   = '0;
				row_d   = '0;
				ovf_d   = 1'b0;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ----- sv/mbb_checker.sv -----
// Port-level checks for the bounding-box block, bound to the top level.
// Depends on mbb_pkg and mask_blob_bounding_boxes_core.
module mbb_checker import mbb_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  pready,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  last_pixel,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic                  box_present,
	input logic [COORD_BITS-1:0] box_x,
	input logic                  last_box
);
	// The end of a frame always starts a merge, so the block must go busy.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_pixel |=> in_stall)
		else $error("no busy cycle after last pixel");

	// A result without a box only comes as the sole result of an empty frame.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !box_present |-> last_box)
		else $error("empty result not marked last");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(box_x))
		else $error("stalled result changed");
endmodule

bind mask_blob_bounding_boxes_core mbb_checker u_mbb_checker (
	.clk(clk), .arst_n(arst_n), .pready(pready), .in_valid(in_valid),
	.in_stall(in_stall), .last_pixel(last_pixel), .out_valid(out_valid),
	.out_stall(out_stall), .box_present(box_present), .box_x(box_x),
	.last_box(last_box)
);

// ----- dv/tb_mask_blob_bounding_boxes_core.sv -----
// Self-checking testbench for mask_blob_bounding_boxes_core: directed and random mask frames.
// Depends on mbb_pkg and the block's RTL; holds its own bit-accurate box predictor.
module tb_mask_blob_bounding_boxes_core;
	import mbb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 1000000;
	localparam int SETTLE_CYCLES  = 60;
	localparam int RANDOM_ITEMS   = 150;

	// One emitted box as the block should present it.
	typedef struct {
		bit        present;
		bit [11:0] x;
		bit [11:0] y;
		bit [12:0] w;
		bit [12:0] h;
		bit        ovf;
		bit        lastb;
	} box_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_W-1:0]     paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_stall;
	logic [7:0]            pixel_confidence;
	logic                  last_pixel;
	logic                  out_valid;
	logic                  out_stall;
	logic                  box_present;
	logic [COORD_BITS-1:0] box_x;
	logic [COORD_BITS-1:0] box_y;
	logic [SIZE_W-1:0]     box_width;
	logic [SIZE_W-1:0]     box_height;
	logic                  overflow;
	logic                  last_box;

	mask_blob_bounding_boxes_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.pixel_confidence(pixel_confidence), .last_pixel(last_pixel),
		.out_valid(out_valid), .out_stall(out_stall),
		.box_present(box_present), .box_x(box_x), .box_y(box_y),
		.box_width(box_width), .box_height(box_height),
		.overflow(overflow), .last_box(last_box)
	);

	// The predictor keeps its own copy of the registers and the box list.
	int unsigned thresh_q, win_q, fw_q;
	int          box_l[MAX_BOXES];
	int          box_t_[MAX_BOXES];
	int          box_w[MAX_BOXES];
	int          box_h[MAX_BOXES];
	int unsigned n_boxes, col_pos, row_pos;
	bit          dropped;

	box_result_t expected_boxes[$];

	int unsigned pixels_sent, frames_sent, boxes_seen, mismatches;
	int unsigned idle_count;
	bit          failed;
	bit          sender_gaps, receiver_gaps;
	int unsigned hold_left, burst_left;

	initial begin
		clk = 1'b0;
	end
	always #2 clk = ~clk;

	function automatic bit rects_meet(int ax, int ay, int aw, int ah,
			int bx, int by, int bw, int bh);
		return ax < bx + bw && bx < ax + aw && ay < by + bh && by < ay + ah;
	endfunction

	// Foreground pixel: grow the first overlapping box and move it to the
	// front, otherwise append a 1x1 box or flag a dropped one.
	function automatic void absorb_pixel(int px, int py);
		int side, reach, l, t, r, b;
		side  = (win_q == 0) ? 1 : int'(win_q);
		reach = side / 2;
		for (int k = 0; k < int'(n_boxes); k++) begin
			if (rects_meet(px - reach, py - reach, side, side,
					box_l[k], box_t_[k], box_w[k], box_h[k])) begin
				l = (box_l[k] < px) ? box_l[k] : px;
				t = (box_t_[k] < py) ? box_t_[k] : py;
				r = (box_l[k] + box_w[k] - 1 > px) ? box_l[k] + box_w[k] - 1 : px;
				b = (box_t_[k] + box_h[k] - 1 > py) ? box_t_[k] + box_h[k] - 1 : py;
				box_l[k] = box_l[0];
				box_t_[k] = box_t_[0];
				box_w[k] = box_w[0];
				box_h[k] = box_h[0];
				box_l[0] = l;
				box_t_[0] = t;
				box_w[0] = r - l + 1;
				box_h[0] = b - t + 1;
				return;
			end
		end
		if (n_boxes < MAX_BOXES) begin
			box_l[n_boxes] = px;
			box_t_[n_boxes] = py;
			box_w[n_boxes] = 1;
			box_h[n_boxes] = 1;
			n_boxes++;
		end else begin
			dropped = 1'b1;
		end
	endfunction

	// Union overlapping pairs until a full pass finds none.
	function automatic void merge_boxes();
		bit again;
		int j, l, t, r, b;
		do begin
			again = 1'b0;
			for (int i = 0; i < int'(n_boxes); i++) begin
				j = i + 1;
				while (j < int'(n_boxes)) begin
					if (rects_meet(box_l[i], box_t_[i], box_w[i], box_h[i],
							box_l[j], box_t_[j], box_w[j], box_h[j])) begin
						l = (box_l[i] < box_l[j]) ? box_l[i] : box_l[j];
						t = (box_t_[i] < box_t_[j]) ? box_t_[i] : box_t_[j];
						r = (box_l[i] + box_w[i] > box_l[j] + box_w[j]) ?
							box_l[i] + box_w[i] : box_l[j] + box_w[j];
						b = (box_t_[i] + box_h[i] > box_t_[j] + box_h[j]) ?
							box_t_[i] + box_h[i] : box_t_[j] + box_h[j];
						box_l[i] = l;
						box_t_[i] = t;
						box_w[i] = r - l;
						box_h[i] = b - t;
						for (int m = j; m + 1 < int'(n_boxes); m++) begin
							box_l[m] = box_l[m+1];
							box_t_[m] = box_t_[m+1];
							box_w[m] = box_w[m+1];
							box_h[m] = box_h[m+1];
						end
						n_boxes--;
						again = 1'b1;
					end else begin
						j++;
					end
				end
			end
		end while (again);
	endfunction

	// Advance the predictor by one accepted pixel and queue any boxes it ends.
	function automatic void predict_pixel(bit [7:0] conf, bit lastp);
		int unsigned fw;
		box_result_t e;
		fw = (fw_q > 4096) ? 4096 : fw_q;
		if (conf >= thresh_q) absorb_pixel(int'(col_pos), int'(row_pos));
		if (col_pos + 1 >= fw) begin
			col_pos = 0;
			row_pos = (row_pos + 1) & 12'hFFF;
		end else begin
			col_pos = (col_pos + 1) & 12'hFFF;
		end
		if (!lastp) return;
		merge_boxes();
		if (n_boxes == 0) begin
			e = '{present: 1'b0, x: '0, y: '0, w: '0, h: '0, ovf: dropped, lastb: 1'b1};
			expected_boxes.push_back(e);
		end else begin
			for (int k = 0; k < int'(n_boxes); k++) begin
				e.present = 1'b1;
				e.x = box_l[k][11:0];
				e.y = box_t_[k][11:0];
				e.w = box_w[k][12:0];
				e.h = box_h[k][12:0];
				e.ovf = dropped;
				e.lastb = (k + 1 == int'(n_boxes));
				expected_boxes.push_back(e);
			end
		end
		n_boxes = 0;
		col_pos = 0;
		row_pos = 0;
		dropped = 1'b0;
		frames_sent++;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one pixel request and return at the edge that accepts it.
	task automatic send_pixel(input bit [7:0] conf, input bit lastp);
		int unsigned gap;
		gap = sender_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_confidence <= conf;
		last_pixel <= lastp;
		do @(posedge clk); while (in_stall);
		predict_pixel(conf, lastp);
		pixels_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_boxes.size() != 0) @(posedge clk);
		// The sequencer has cleared its frame state by the time the final box leaves.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write in a setup and an access cycle; only called while idle.
	task automatic write_reg(input logic [ADDR_W-3:0] idx, input int unsigned value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MIN_CONF: thresh_q = value & 8'hFF;
			REG_WINDOW:   win_q = value & 6'h3F;
			REG_FRAME_W:  fw_q = value & 13'h1FFF;
			default: ;
		endcase
	endtask

	task automatic set_config(input int unsigned thr, input int unsigned win,
			input int unsigned fw);
		write_reg(REG_MIN_CONF, thr);
		write_reg(REG_WINDOW, win);
		write_reg(REG_FRAME_W, fw);
	endtask

	// Random frame: 15 percent of pixels fully random, the rest foreground at fg_pct percent.
	task automatic send_random_frame(input int unsigned n, input int unsigned fg_pct);
		bit [7:0] c;
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 15)
				c = 8'($urandom_range(0, 255));
			else if ($urandom_range(0, 99) < fg_pct)
				c = 8'($urandom_range(thresh_q > 255 ? 255 : thresh_q, 255));
			else
				c = (thresh_q == 0) ? 8'd0 : 8'($urandom_range(0, thresh_q - 1));
			send_pixel(c, i + 1 == n);
		end
	endtask

	// Threshold edges, the empty frame and a lone foreground pixel.
	task automatic test_directed_basics();
		set_config(128, 17, 8);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd127, 1'b0);
		send_pixel(8'd128, 1'b0);
		send_pixel(8'd200, 1'b1);
		send_pixel(8'd0, 1'b1);
		send_pixel(8'd255, 1'b1);
		drain();
		set_config(0, 3, 4);
		send_pixel(8'd0, 1'b1);
		drain();
		set_config(255, 3, 4);
		send_pixel(8'd254, 1'b0);
		send_pixel(8'd255, 1'b1);
		drain();
	endtask

	// Zero, minimum, even and maximum window sides.
	task automatic test_window_sides();
		int unsigned sides[4] = '{0, 1, 4, 63};
		foreach (sides[s]) begin
			set_config(100, sides[s], 4);
			send_random_frame(16, 40);
			drain();
		end
	endtask

	// Zero frame width, the largest legal width and an oversized one.
	task automatic test_frame_widths();
		int unsigned widths[3] = '{0, 4096, 8191};
		foreach (widths[s]) begin
			set_config(90, 5, widths[s]);
			send_random_frame(10, 50);
			drain();
		end
	endtask

	// With a one-pixel window every foreground pixel starts a box of its own,
	// so a solid run fills the box list past its capacity.
	task automatic test_overflow();
		set_config(128, 1, 32);
		for (int i = 0; i < 70; i++)
			send_pixel(8'd255, i == 69);
		drain();
	endtask

	// The receiver holds off for a long time while frames keep arriving.
	task automatic test_backpressure();
		set_config(60, 7, 6);
		hold_left = 3000;
		for (int f = 0; f < 4; f++) send_random_frame(12, 40);
		drain();
	endtask

	// Random registers and frames; mostly moderate blobs, some sparse or dense.
	task automatic test_random_frames();
		int unsigned start, fw, n, pct;
		start = pixels_sent;
		while (pixels_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				sender_gaps = $urandom_range(0, 3) != 0;
				receiver_gaps = $urandom_range(0, 3) != 0;
			end
			fw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 12);
			set_config($urandom_range(0, 255), $urandom_range(0, 63), fw);
			n = $urandom_range(1, 40);
			pct = $urandom_range(0, 9) < 7 ? $urandom_range(20, 50) : $urandom_range(0, 100);
			send_random_frame(n, pct);
			drain();
		end
	endtask

	// Receiver: random short stalls, occasional bursts, and the long hold-off.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (burst_left > 0) begin
			out_stall <= 1'b1;
			burst_left <= burst_left - 1;
		end else if (receiver_gaps && $urandom_range(0, 99) < 3) begin
			out_stall <= 1'b1;
			burst_left <= $urandom_range(10, 40);
		end else begin
			out_stall <= receiver_gaps && ($urandom_range(0, 99) < 30);
		end
	end

	// Compare each accepted box with the oldest prediction.
	always @(posedge clk) begin
		box_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			boxes_seen++;
			if (expected_boxes.size() == 0) begin
				failed = 1'b1;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected box x=%0d y=%0d w=%0d h=%0d", box_x, box_y,
						box_width, box_height);
			end else begin
				e = expected_boxes.pop_front();
				if (box_present !== e.present || box_x !== e.x || box_y !== e.y ||
						box_width !== e.w || box_height !== e.h ||
						overflow !== e.ovf || last_box !== e.lastb) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= 10) begin
						$display("box mismatch: exp p%0d (%0d,%0d) %0dx%0d ovf%0d last%0d",
							e.present, e.x, e.y, e.w, e.h, e.ovf, e.lastb);
						$display("              got p%0d (%0d,%0d) %0dx%0d ovf%0d last%0d",
							box_present, box_x, box_y, box_width, box_height,
							overflow, last_box);
					end
				end
			end
		end
	end

	// Watchdog: cycles in which neither channel nor the register port moves.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		pixel_confidence = '0;
		last_pixel = 1'b0;
		out_stall = 1'b0;
		thresh_q = 128;
		win_q = 17;
		fw_q = 256;
		n_boxes = 0;
		col_pos = 0;
		row_pos = 0;
		dropped = 1'b0;
		idle_count = 0;
		hold_left = 0;
		burst_left = 0;
		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_basics();
		test_window_sides();
		test_frame_widths();
		test_overflow();
		test_backpressure();
		test_random_frames();
		drain();

		$display("Covered %0d pixels in %0d frames, %0d boxes checked, %0d mismatches.",
			pixels_sent, frames_sent, boxes_seen, mismatches);
		if (!failed && expected_boxes.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
sv/mbb_pkg.sv
sv/mbb_ram.sv
sv/mbb_regs.sv
sv/mask_blob_bounding_boxes_core.sv
sv/mbb_checker.sv
dv/tb_mask_blob_bounding_boxes_core.sv
